@@ rtl/skt_pkg.sv @@
// Shared types, sizes and codes for the sorted key table engine.
package skt_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int KEY_BYTES   = 8;
  localparam int HANDLE_BITS = 32;

  localparam int KEY_W    = 64;
  localparam int HIN_W    = 32;
  localparam int HANDLE_W = (HANDLE_BITS < HIN_W) ? HANDLE_BITS : HIN_W;
  localparam int ADDR_W   = $clog2(TABLE_DEPTH);
  localparam int CNT_W    = $clog2(TABLE_DEPTH + 1);
  localparam int STAT_W   = 3;
  localparam int POS_W    = 7;
  localparam int REQ_W    = 2;

  localparam logic [KEY_W-1:0] KEY_MASK = ~(KEY_W'(0)) << (KEY_W - KEY_BYTES * 8);

  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL    = 3'd1;
  localparam logic [STAT_W-1:0] ST_DUP     = 3'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY   = 3'd3;
  localparam logic [STAT_W-1:0] ST_MISSING = 3'd4;

  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
  } entry_t;

endpackage

@@ rtl/skt_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module skt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ rtl/sorted_key_table_engine_core.sv @@
// Top level of the sorted key table engine: sequencer around one entry RAM.
// Flow: a binary search halves the window step by step, then the candidate is
//   verified, the request decided and the result posted; insert shifts the entries
//   above the slot up and stores the new entry, remove shifts them down.
// Throughput: one word at a time; in_ready is high only while the sequencer idles.
// Reset: synchronous, clears the entry count, sequencer and output valid; the
//   entry RAM is not cleared, since only entries below the count are ever used.
module sorted_key_table_engine_core
  import skt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [REQ_W-1:0]  req_type,
  input  logic [KEY_W-1:0]  key_name,
  input  logic [HIN_W-1:0]  handle_value,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [STAT_W-1:0] status,
  output logic              found,
  output logic [HIN_W-1:0]  handle_out,
  output logic [POS_W-1:0]  position,
  output logic [POS_W-1:0]  entry_count
);

  typedef enum logic [3:0] {
    S_IDLE, S_SEARCH, S_CMP, S_VERIFY, S_DECIDE,
    S_UP_R, S_UP_W, S_DN_R, S_DN_W, S_DONE
  } state_t;

  state_t              state;
  logic [REQ_W-1:0]    req;
  logic [KEY_W-1:0]    key;
  logic [HANDLE_W-1:0] hval;
  logic [CNT_W-1:0]    used;
  logic [CNT_W-1:0]    lo;
  logic [CNT_W-1:0]    hi;
  logic [CNT_W-1:0]    mid;
  logic [CNT_W-1:0]    idx;
  logic                hit;
  logic [HANDLE_W-1:0] hout;
  logic [STAT_W-1:0]   stat;

  // RAM port signals
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_wr_addr;
  entry_t             ram_wr_data;
  logic [ADDR_W-1:0]  ram_rd_addr;
  entry_t             ram_rd_data;

  logic [CNT_W-1:0]   mid_next;
  logic               out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;
  // Midpoint of the open search window; lo + half the span never overflows.
  assign mid_next = lo + ((hi - lo) >> 1);

  skt_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // RAM address and write control, steered by the sequencer state.
  always_comb begin
    ram_we      = 1'b0;
    ram_wr_addr = idx[ADDR_W-1:0];
    ram_wr_data = ram_rd_data;
    ram_rd_addr = '0;
    unique case (state)
      S_SEARCH: begin
        // Probe the midpoint while the window is open, else fetch the candidate.
        if (lo < hi) begin
          ram_rd_addr = mid_next[ADDR_W-1:0];
        end else begin
          ram_rd_addr = lo[ADDR_W-1:0];
        end
      end
      S_UP_R: begin
        if (idx > lo) begin
          ram_rd_addr = ADDR_W'(idx - CNT_W'(1));
        end else begin
          // Shift done: drop the new entry into the opened slot.
          ram_we           = 1'b1;
          ram_wr_addr      = lo[ADDR_W-1:0];
          ram_wr_data.key    = key;
          ram_wr_data.handle = hval;
        end
      end
      S_UP_W: begin
        ram_we = 1'b1;
      end
      S_DN_R: begin
        if ((idx + CNT_W'(1)) < used) begin
          ram_rd_addr = ADDR_W'(idx + CNT_W'(1));
        end
      end
      S_DN_W: begin
        ram_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Sequencer, working registers and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      used      <= '0;
      out_valid <= 1'b0;
    end else begin
      // Drop the taken result word, unless a new one replaces it this cycle.
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            req  <= req_type;
            key  <= key_name & KEY_MASK;
            hval <= HANDLE_W'(handle_value);
            lo   <= '0;
            hi   <= used;
            hit  <= 1'b0;
            hout <= '0;
            stat <= ST_OK;
            if (req_type == REQ_REMOVE && used == '0) begin
              stat  <= ST_EMPTY;
              state <= S_DONE;
            end else if (req_type == REQ_INSERT || req_type == REQ_REMOVE ||
                         req_type == REQ_LOOKUP) begin
              state <= S_SEARCH;
            end else begin
              // Unused request code: report ok and leave the table alone.
              state <= S_DONE;
            end
          end
        end
        S_SEARCH: begin
          if (lo < hi) begin
            mid   <= mid_next;
            state <= S_CMP;
          end else if (lo < used) begin
            state <= S_VERIFY;
          end else begin
            state <= S_DECIDE;
          end
        end
        S_CMP: begin
          // Narrow the window around the lower bound.
          if (ram_rd_data.key < key) begin
            lo <= mid + CNT_W'(1);
          end else begin
            hi <= mid;
          end
          state <= S_SEARCH;
        end
        S_VERIFY: begin
          hit   <= (ram_rd_data.key == key);
          hout  <= ram_rd_data.handle;
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          if (!(req == REQ_LOOKUP && hit)) begin
            hout <= '0;
          end
          unique case (req)
            REQ_INSERT: begin
              if (used == CNT_W'(TABLE_DEPTH)) begin
                stat  <= ST_FULL;
                state <= S_DONE;
              end else if (hit) begin
                stat  <= ST_DUP;
                state <= S_DONE;
              end else begin
                idx   <= used;
                state <= S_UP_R;
              end
            end
            REQ_REMOVE: begin
              if (!hit) begin
                stat  <= ST_MISSING;
                state <= S_DONE;
              end else begin
                idx   <= lo;
                state <= S_DN_R;
              end
            end
            default: begin
              // Lookup: status reflects the match.
              if (!hit) begin
                stat <= ST_MISSING;
              end
              state <= S_DONE;
            end
          endcase
        end
        S_UP_R: begin
          if (idx > lo) begin
            state <= S_UP_W;
          end else begin
            used  <= used + CNT_W'(1);
            state <= S_DONE;
          end
        end
        S_UP_W: begin
          idx   <= idx - CNT_W'(1);
          state <= S_UP_R;
        end
        S_DN_R: begin
          if ((idx + CNT_W'(1)) < used) begin
            state <= S_DN_W;
          end else begin
            used  <= used - CNT_W'(1);
            state <= S_DONE;
          end
        end
        S_DN_W: begin
          idx   <= idx + CNT_W'(1);
          state <= S_DN_R;
        end
        S_DONE: begin
          // Hold the result until the output register frees up.
          if (out_free) begin
            out_valid   <= 1'b1;
            status      <= stat;
            found       <= hit;
            handle_out  <= HIN_W'(hout);
            position    <= POS_W'(lo);
            entry_count <= POS_W'(used);
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The entry count never passes the table depth.
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  // The search window stays ordered while the search runs.
  a_window: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEARCH || state == S_CMP) |-> (lo <= hi))
    else $error("search window inverted");

  // The RAM is written only during a shift or final store.
  a_write_phase: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_UP_R || state == S_UP_W || state == S_DN_W))
    else $error("RAM write outside shift phase");

  // An accepted word makes the block busy on the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while busy");

  // A duplicate report always carries a match.
  a_dup_found: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_DUP) |-> found)
    else $error("duplicate without match");

endmodule
